// ===== rtl/core/psis_pkg.sv =====
// Shared types, constants and the hash fold for the pair-sum index search unit.
// No dependencies; every other file of the block but psis_checker imports this package.
`default_nettype none

package psis_pkg;

    // Array and table geometry. TABLE_SLOTS must stay a power of two: the hash
    // keeps the low address bits of the folded product.
    localparam int unsigned MAX_LEN     = 1024;
    localparam int unsigned TABLE_SLOTS = 2048;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int unsigned COUNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Array generation tag kept with every slot; zero marks a swept slot.
    localparam int unsigned EPOCH_W   = 8;
    localparam int unsigned EPOCH_MAX = (1 << EPOCH_W) - 1;

    localparam logic [VALUE_W-1:0] HASH_MULT = 32'h9E37_79B1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_FOUND    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // One classified element on its way from front to back.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] comp;
        logic [SLOT_W-1:0]  hash_c;
        logic [SLOT_W-1:0]  hash_v;
        logic               last;
        logic               first;
    } psis_item_t;

    // One table slot as stored in the slot memory.
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [INDEX_W-1:0] position;
        logic [VALUE_W-1:0] value;
    } psis_slot_t;

    // Fold the low product word and keep the slot address bits.
    function automatic logic [SLOT_W-1:0] hash_fold(input logic [VALUE_W-1:0] prod);
        logic [VALUE_W-1:0] h;
        h = prod ^ (prod >> 16);
        return h[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psis_front.sv =====
// Front part: accepts elements, holds the target register, forms the complement
// and both hash addresses. Depends on psis_pkg.
`default_nettype none

module psis_front import psis_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [VALUE_W-1:0] cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,
    input  wire logic               s_tlast,
    output logic                    item_valid,
    output psis_item_t              item,
    input  wire logic               item_ready
);

    logic [VALUE_W-1:0] target_reg;
    logic               first_pending_reg;

    logic               s1_valid_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic [VALUE_W-1:0] s1_comp_reg;
    logic               s1_last_reg;
    logic               s1_first_reg;

    logic               s2_valid_reg;
    logic [VALUE_W-1:0] s2_value_reg;
    logic [VALUE_W-1:0] s2_comp_reg;
    logic [VALUE_W-1:0] s2_prod_c_reg;
    logic [VALUE_W-1:0] s2_prod_v_reg;
    logic               s2_last_reg;
    logic               s2_first_reg;

    logic s1_take;
    logic s2_take;
    logic s_accept;

    assign s2_take  = !s2_valid_reg || item_ready;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign s_tready = s1_take;
    assign s_accept = s_tvalid && s1_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg        <= '0;
            first_pending_reg <= 1'b1;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
            if (s_accept) begin
                first_pending_reg <= s_tlast;
            end
            if (s1_take) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_take) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_value_reg <= s_tdata;
            s1_comp_reg  <= target_reg - s_tdata;
            s1_last_reg  <= s_tlast;
            s1_first_reg <= first_pending_reg;
        end
        if (s2_take && s1_valid_reg) begin
            s2_value_reg  <= s1_value_reg;
            s2_comp_reg   <= s1_comp_reg;
            s2_prod_c_reg <= s1_comp_reg * HASH_MULT;
            s2_prod_v_reg <= s1_value_reg * HASH_MULT;
            s2_last_reg   <= s1_last_reg;
            s2_first_reg  <= s1_first_reg;
        end
    end

    assign item_valid   = s2_valid_reg;
    assign item.value   = s2_value_reg;
    assign item.comp    = s2_comp_reg;
    assign item.hash_c  = hash_fold(s2_prod_c_reg);
    assign item.hash_v  = hash_fold(s2_prod_v_reg);
    assign item.last    = s2_last_reg;
    assign item.first   = s2_first_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psis_queue.sv =====
// Short queue of classified elements between front and back.
// Depends on psis_pkg.
`default_nettype none

module psis_queue import psis_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       wr_valid,
    output logic            wr_ready,
    input  wire psis_item_t wr_item,
    output logic            rd_valid,
    input  wire logic       rd_ready,
    output psis_item_t      rd_item
);

    psis_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;

    logic push;
    logic pop;

    assign wr_ready = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = fill_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_step(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_step(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_step(rd_ptr_reg);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psis_back.sv =====
// Back part: probe sequencer over the slot memory, array bookkeeping and the
// result register. Depends on psis_pkg.
`default_nettype none

module psis_back import psis_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire psis_item_t          item,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [INDEX_W-1:0]       m_first,
    output logic [INDEX_W-1:0]       m_second
);

    typedef enum logic [4:0] {
        ST_SWEEP   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_PROBE_C = 5'b00100,
        ST_PROBE_V = 5'b01000,
        ST_EMIT    = 5'b10000
    } back_state_t;

    psis_slot_t slot_mem [TABLE_SLOTS];
    psis_slot_t mem_rdata_reg;
    psis_slot_t mem_wdata;
    logic [SLOT_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;

    back_state_t        state_reg,     state_next;
    logic [EPOCH_W-1:0] epoch_reg,     epoch_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               pair_seen_reg, pair_seen_next;
    logic [SLOT_W-1:0]  sweep_reg,     sweep_next;
    logic [SLOT_W-1:0]  slot_reg,      slot_next;
    logic [SLOT_W-1:0]  probe_reg,     probe_next;
    psis_item_t         cur_reg,       cur_next;
    status_t            res_status_reg, res_status_next;
    logic [INDEX_W-1:0] res_first_reg,  res_first_next;
    logic [INDEX_W-1:0] res_second_reg, res_second_next;
    logic               out_valid_reg,  out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [INDEX_W-1:0] out_first_reg,  out_first_next;
    logic [INDEX_W-1:0] out_second_reg, out_second_next;

    logic              slot_live;
    logic              probe_done;
    logic [SLOT_W-1:0] slot_step;
    logic              out_free;

    assign slot_live  = mem_rdata_reg.tag == epoch_reg;
    assign probe_done = probe_reg == SLOT_W'(TABLE_SLOTS - 1);
    assign slot_step  = (slot_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        count_next      = count_reg;
        pair_seen_next  = pair_seen_reg;
        sweep_next      = sweep_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_second_next = res_second_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        item_ready      = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = slot_reg;
        mem_wdata.tag      = epoch_reg;
        mem_wdata.position = INDEX_W'(count_reg);
        mem_wdata.value    = cur_reg.value;

        case (state_reg)
            ST_SWEEP: begin
                mem_we     = 1'b1;
                mem_addr   = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    sweep_next = '0;
                    epoch_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (item_valid) begin
                    if (item.first && epoch_reg == EPOCH_W'(EPOCH_MAX)) begin
                        // tags about to alias: wipe them before this array
                        state_next = ST_SWEEP;
                    end else begin
                        item_ready = 1'b1;
                        cur_next   = item;
                        if (item.first) begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                        if (pair_seen_reg) begin
                            if (item.last) begin
                                count_next     = '0;
                                pair_seen_next = 1'b0;
                            end
                        end else if (count_reg >= COUNT_W'(MAX_LEN)) begin
                            res_status_next = STATUS_OVERFLOW;
                            res_first_next  = '0;
                            res_second_next = '0;
                            pair_seen_next  = !item.last;
                            if (item.last) begin
                                count_next = '0;
                            end
                            state_next = ST_EMIT;
                        end else begin
                            mem_re     = 1'b1;
                            mem_addr   = item.hash_c;
                            slot_next  = item.hash_c;
                            probe_next = '0;
                            state_next = ST_PROBE_C;
                        end
                    end
                end
            end
            ST_PROBE_C: begin
                if (slot_live && mem_rdata_reg.value == cur_reg.comp) begin
                    res_status_next = STATUS_FOUND;
                    res_first_next  = mem_rdata_reg.position;
                    res_second_next = INDEX_W'(count_reg);
                    pair_seen_next  = !cur_reg.last;
                    if (cur_reg.last) begin
                        count_next = '0;
                    end
                    state_next = ST_EMIT;
                end else if (!slot_live || probe_done) begin
                    mem_re     = 1'b1;
                    mem_addr   = cur_reg.hash_v;
                    slot_next  = cur_reg.hash_v;
                    probe_next = '0;
                    state_next = ST_PROBE_V;
                end else begin
                    mem_re     = 1'b1;
                    mem_addr   = slot_step;
                    slot_next  = slot_step;
                    probe_next = probe_reg + 1'b1;
                end
            end
            ST_PROBE_V: begin
                if (!slot_live || mem_rdata_reg.value == cur_reg.value) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                    if (cur_reg.last) begin
                        count_next      = '0;
                        res_status_next = STATUS_NONE;
                        res_first_next  = '0;
                        res_second_next = '0;
                        state_next      = ST_EMIT;
                    end
                end else if (probe_done) begin
                    res_status_next = STATUS_OVERFLOW;
                    res_first_next  = '0;
                    res_second_next = '0;
                    pair_seen_next  = !cur_reg.last;
                    if (cur_reg.last) begin
                        count_next = '0;
                    end
                    state_next = ST_EMIT;
                end else begin
                    mem_re     = 1'b1;
                    mem_addr   = slot_step;
                    slot_next  = slot_step;
                    probe_next = probe_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_first_next  = res_first_reg;
                    out_second_next = res_second_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            epoch_reg     <= '0;
            count_reg     <= '0;
            pair_seen_reg <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            count_reg     <= count_next;
            pair_seen_reg <= pair_seen_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        probe_reg      <= probe_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            mem_rdata_reg <= slot_mem[mem_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_first  = out_first_reg;
    assign m_second = out_second_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pair_sum_index_search_unit.sv =====
// Path of an element: the front registers and the queue, then in the back the lookup
// read, the insert read and the write; a result then passes ST_EMIT into the output
// register behind m_tdata. A pair found by the lookup skips the insert read and write.
// The back takes a new element only once the single-port slot memory is done with the last.
// Reset (aresetn low, synchronous): a sweep of every slot of the slot memory follows;
// the same sweep reruns after every 255 arrays when the array tag wraps.
`default_nettype none

module pair_sum_index_search_unit import psis_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // target_sum register write
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,   // [31:0] target_sum
    // element stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,     // [31:0] element_value
    input  wire logic         s_tlast,     // last_element
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata      // [1:0] status, [11:2] first_index,
                                           // [21:12] second_index, [23:22] zero
);

    // front -> queue
    logic       fq_valid;
    logic       fq_ready;
    psis_item_t fq_item;

    // queue -> back
    logic       qb_valid;
    logic       qb_ready;
    psis_item_t qb_item;

    logic [STATUS_W-1:0] m_status;
    logic [INDEX_W-1:0]  m_first;
    logic [INDEX_W-1:0]  m_second;

    // Accept elements, form the complement and both hash addresses.
    psis_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (fq_valid),
        .item       (fq_item),
        .item_ready (fq_ready)
    );

    // Hold classified elements while the back end probes.
    psis_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    // Probe the table, insert or report, and hold the result word.
    psis_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_status),
        .m_first    (m_first),
        .m_second   (m_second)
    );

    // Pack the result word, status in the lowest bits.
    assign m_tdata = {2'b00, m_second, m_first, m_status};

endmodule

`default_nettype wire

// ===== rtl/core/psis_checker.sv =====
// Port-level checks on the pair-sum index search unit, attached by bind.
// Depends on the ports of pair_sum_index_search_unit only.
`default_nettype none

module psis_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[23:22] == 2'b00)
        else $error("bad status code or padding");

    a_idle_indices: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd1 |-> m_tdata[21:2] == 20'd0)
        else $error("indices set without a pair");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd1 |-> m_tdata[11:2] < m_tdata[21:12])
        else $error("pair indices out of order");

endmodule

bind pair_sum_index_search_unit psis_checker u_psis_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for pair_sum_index_search_unit: streams arrays of elements,
// predicts each result with an in-bench hash-table search and checks every result word.
// Depends on psis_pkg (geometry constants, status_t) and the unit under test.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psis_pkg::*;

    localparam int unsigned SETTLE    = 40;   // cycles allowed for dropped elements to drain
    localparam int unsigned LONG_HOLD = 400;  // receiver hold-off that backs the unit up

    typedef struct {
        logic [31:0] value;
        logic        last;
    } element_t;

    typedef struct {
        status_t            status;
        logic [INDEX_W-1:0] first_idx;
        logic [INDEX_W-1:0] second_idx;
    } search_result_t;

    // Clock, reset and unit ports; the ones the bench drives are known from time zero.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    pair_sum_index_search_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Words waiting to be offered, and results the search should still produce.
    element_t       element_queue[$];
    search_result_t pending_results[$];

    // Private copy of the search state: target, hash table and array progress.
    logic [31:0]        model_target = '0;
    logic [31:0]        tbl_value [TABLE_SLOTS];
    logic [INDEX_W-1:0] tbl_pos   [TABLE_SLOTS];
    bit                 tbl_used  [TABLE_SLOTS];
    int unsigned        elem_idx     = 0;
    bit                 array_done   = 1'b0;

    // Keys that land on one home slot (padded if too few are found), to force long probe chains.
    logic [31:0] chain_keys[$];

    // Stimulus controls, changed by the sequencer at falling edges only.
    bit gaps_on      = 1'b0;
    bit hold_off_req = 1'b0;

    int unsigned fail_count      = 0;
    int unsigned words_accepted  = 0;
    int unsigned arrays_finished = 0;
    int unsigned results_checked = 0;
    int unsigned targets_tried   = 0;

    // ------------------------------------------------------------------
    // Search predictor
    // ------------------------------------------------------------------

    // Multiplicative hash: low product word, fold the upper half down, keep the slot bits.
    function automatic int unsigned home_slot(logic [31:0] key);
        logic [31:0] h;
        h = key * 32'd2654435761;
        h = h ^ (h >> 16);
        return h % TABLE_SLOTS;
    endfunction

    // Slot holding key, else the first free slot on its probe path,
    // else TABLE_SLOTS when every slot is taken by another key.
    function automatic int unsigned find_slot(logic [31:0] key);
        int unsigned s;
        s = home_slot(key);
        for (int unsigned n = 0; n < TABLE_SLOTS; n++) begin
            if (!tbl_used[s] || tbl_value[s] == key)
                return s;
            s = (s + 1) % TABLE_SLOTS;
        end
        return TABLE_SLOTS;
    endfunction

    // Advance the predicted search by one accepted word; queue any result it causes.
    function automatic void track_element(logic [31:0] value, logic last);
        search_result_t r;
        logic [31:0]    comp;
        int unsigned    s;
        int unsigned    t;
        bit             emit_now;
        emit_now     = 1'b0;
        r.status     = STATUS_NONE;
        r.first_idx  = '0;
        r.second_idx = '0;
        // A fresh array starts with an empty table.
        if (elem_idx == 0 && !array_done)
            foreach (tbl_used[k]) tbl_used[k] = 1'b0;
        if (!array_done) begin
            if (elem_idx >= MAX_LEN) begin
                r.status   = STATUS_OVERFLOW;
                array_done = 1'b1;
                emit_now   = 1'b1;
            end else begin
                comp = model_target - value;
                s    = find_slot(comp);
                if (s < TABLE_SLOTS && tbl_used[s]) begin
                    r.status     = STATUS_FOUND;
                    r.first_idx  = tbl_pos[s];
                    r.second_idx = INDEX_W'(elem_idx);
                    array_done   = 1'b1;
                    emit_now     = 1'b1;
                end else begin
                    t = find_slot(value);
                    if (t >= TABLE_SLOTS) begin
                        r.status   = STATUS_OVERFLOW;
                        array_done = 1'b1;
                        emit_now   = 1'b1;
                    end else begin
                        // Insert or overwrite: a later duplicate takes over the slot.
                        tbl_value[t] = value;
                        tbl_pos[t]   = INDEX_W'(elem_idx);
                        tbl_used[t]  = 1'b1;
                        elem_idx     = elem_idx + 1;
                        emit_now     = last;
                    end
                end
            end
        end
        if (emit_now)
            pending_results = {pending_results, r};
        if (last) begin
            elem_idx   = 0;
            array_done = 1'b0;
            arrays_finished++;
        end
    endfunction

    // Compare one result word with the oldest prediction, field by field.
    function automatic void check_result(logic [23:0] word);
        search_result_t e;
        if (pending_results.size() == 0) begin
            $error("result word %h arrived with no prediction waiting", word);
            fail_count++;
            return;
        end
        e = pending_results.pop_front();
        results_checked++;
        if (word[1:0] != e.status) begin
            $error("status: expected %0d, got %0d", e.status, word[1:0]);
            fail_count++;
        end
        if (word[11:2] != e.first_idx) begin
            $error("first_index: expected %0d, got %0d", e.first_idx, word[11:2]);
            fail_count++;
        end
        if (word[21:12] != e.second_idx) begin
            $error("second_index: expected %0d, got %0d", e.second_idx, word[21:12]);
            fail_count++;
        end
        if (word[23:22] != 2'b00) begin
            $error("padding: expected 0, got %0d", word[23:22]);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Element driver: offer queued words, with random gaps between them
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge aclk) begin : element_driver
        element_t nxt;
        bit       load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            // The word on the bus was taken at this edge: predict its effect.
            if (s_tvalid) begin
                track_element(s_tdata, s_tlast);
                words_accepted++;
            end
            load = 1'b0;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (element_queue.size() > 0) begin
                nxt      = element_queue.pop_front();
                load     = 1'b1;
                s_tdata  <= nxt.value;
                s_tlast  <= nxt.last;
                if (gaps_on && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 5);
            end
            // Single assignment per edge, so a back-to-back word keeps tvalid high.
            s_tvalid <= load;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check accepted words, stall tready at random
    // ------------------------------------------------------------------
    int unsigned recv_gap   = 0;
    int unsigned hold_left  = 0;
    bit          hold_taken = 1'b0;

    always @(posedge aclk) begin : result_monitor
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_off_req && !hold_taken) begin
                // Long hold-off: let results pile up until the input side stalls.
                hold_taken <= 1'b1;
                hold_left  <= LONG_HOLD;
                m_tready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                recv_gap <= $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one array; the final word carries tlast.
    task automatic send_array(input logic [31:0] vals[$]);
        element_t w;
        foreach (vals[k]) begin
            w.value = vals[k];
            w.last  = (k == vals.size() - 1);
            element_queue = {element_queue, w};
        end
    endtask

    // Hold until every word is in and every result out, then let dropped words drain.
    task automatic settle();
        while (element_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write target_sum while the unit is idle and mirror it in the predictor.
    task automatic set_target(logic [31:0] t);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        model_target = t;
        targets_tried++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            5: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            6, 7:    return 32'($signed($urandom_range(0, 16)) - 8);
            8, 9:    return chain_keys[$urandom_range(0, chain_keys.size() - 1)];
            default: return $urandom;
        endcase
    endfunction

    // Queue random arrays until about budget words are waiting. Arrays of two or more words
    // carry a planted pair 60 times in 100, some with a duplicate of the earlier partner in between.
    task automatic queue_random_arrays(int unsigned budget, int unsigned max_len);
        logic [31:0] vals[$];
        int unsigned len;
        int unsigned i;
        int unsigned j;
        int unsigned k;
        int unsigned queued;
        queued = 0;
        while (queued < budget) begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(1, max_len);
            else
                len = $urandom_range(1, (max_len < 6) ? max_len : 6);
            vals.delete();
            repeat (len) vals = {vals, pick_value()};
            if (len >= 2 && $urandom_range(0, 99) < 60) begin
                j       = $urandom_range(1, len - 1);
                i       = $urandom_range(0, j - 1);
                vals[j] = model_target - vals[i];
                if (j - i >= 2 && $urandom_range(0, 1) == 1) begin
                    k       = $urandom_range(i + 1, j - 1);
                    vals[k] = vals[i];
                end
            end
            send_array(vals);
            queued += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [31:0] cand;
        logic [31:0] phase_target[6];
        int unsigned chain_home;
        int unsigned tries;

        foreach (tbl_used[k]) tbl_used[k] = 1'b0;

        // Gather keys sharing one home slot.
        chain_home = home_slot($urandom);
        tries      = 0;
        while (chain_keys.size() < 8 && tries < 400000) begin
            cand = $urandom;
            if (home_slot(cand) == chain_home)
                chain_keys = {chain_keys, cand};
            tries++;
        end
        if (chain_keys.size() == 0)
            chain_keys = {chain_keys, 32'h0000_0000};
        while (chain_keys.size() < 3)
            chain_keys = {chain_keys, chain_keys[0] + 32'd1};

        // Reset once; the unit's table sweep afterwards shows up as a stalled tready.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single element, plain pair, duplicate overwrite, dropping after
        // a hit, wrap-around sums and a pair found at the end of a probe chain.
        set_target(32'h0000_0000);
        @(negedge aclk);
        send_array('{32'd42});
        send_array('{32'd7, -32'd7});
        send_array('{32'd3, 32'd3, -32'd3});
        send_array('{32'd5, -32'd5, 32'd9, 32'd9});
        send_array('{32'h8000_0000, 32'h8000_0000});
        send_array('{32'h7FFF_FFFF, chain_keys[0], chain_keys[1], -chain_keys[1]});
        settle();
        set_target(32'h7FFF_FFFF);
        @(negedge aclk);
        send_array('{32'h7FFF_FFFF, 32'h0000_0000});
        settle();
        set_target(32'h8000_0000);
        @(negedge aclk);
        send_array('{32'h7FFF_FFFF, 32'h0000_0001});
        settle();
        set_target(32'hFFFF_FFFF);
        @(negedge aclk);
        send_array('{32'h0000_0000, 32'hFFFF_FFFF});
        settle();

        // Random phases, each under its own target; the single-element phase pushes
        // the array count past the tag wrap and carries the long receiver hold-off.
        phase_target[0] = $urandom;
        phase_target[1] = 32'h8000_0000;
        phase_target[2] = 32'($signed($urandom_range(0, 40)) - 20);
        phase_target[3] = 32'h7FFF_FFFF;
        phase_target[4] = 32'hFFFF_FFFF;
        phase_target[5] = $urandom;
        for (int p = 0; p < 6; p++) begin
            set_target(phase_target[p]);
            @(negedge aclk);
            gaps_on = (p != 1) && (p != 5);
            if (p == 2) begin
                hold_off_req = 1'b1;
                queue_random_arrays(280, 1);
            end else begin
                queue_random_arrays(40, 24);
            end
            settle();
        end

        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            fail_count++;
        end
        $display("summary: %0d words in %0d arrays, %0d results checked, %0d targets",
                 words_accepted, arrays_finished, results_checked, targets_tried);
        $display("summary: %0d chained keys, %0d mismatches", chain_keys.size(), fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/psis_pkg.sv
rtl/core/psis_front.sv
rtl/core/psis_queue.sv
rtl/core/psis_back.sv
rtl/core/pair_sum_index_search_unit.sv
rtl/core/psis_checker.sv
tb/testbench.sv
